// ----- sv/s2x_pkg.sv -----
// ----------------------------------------------------------------------------
// s2x_pkg
// Shared constants and transfer types of the pixel upscaler.
// ----------------------------------------------------------------------------
package s2x_pkg;

  localparam int MaxLine = 1024;
  localparam int MaxRows = 1024;

  localparam int ColW    = $clog2(MaxLine);
  localparam int RowW    = $clog2(MaxRows);
  localparam int LenW    = $clog2(MaxLine + 1);
  localparam int RowLenW = $clog2(MaxRows + 1);

  localparam int PixW   = 32;
  localparam int CoordW = 10;
  localparam int DimW   = 11;
  localparam int ModeW  = 2;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgScaleMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLineWidth   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

  localparam logic [ModeW-1:0] ModeCopy = 2'd0;
  localparam logic [ModeW-1:0] Mode2x   = 2'd1;

  localparam logic [DimW-1:0] LineWidthReset   = 11'd256;
  localparam logic [DimW-1:0] FrameHeightReset = 11'd192;

  localparam logic KindPixel = 1'b0;
  localparam logic KindFlush = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [PixW-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] src_x;
    logic [CoordW-1:0] src_y;
    logic [PixW-1:0]   top_left;
    logic [PixW-1:0]   top_right;
    logic [PixW-1:0]   bottom_left;
    logic [PixW-1:0]   bottom_right;
    logic [PixW-1:0]   center;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic [PixW-1:0] b;
    logic [PixW-1:0] d;
    logic [PixW-1:0] e;
    logic [PixW-1:0] f;
    logic [PixW-1:0] h;
  } nbr_t;

  typedef struct packed {
    logic [PixW-1:0] e0;
    logic [PixW-1:0] e1;
    logic [PixW-1:0] e2;
    logic [PixW-1:0] e3;
  } corners_t;

endpackage

// ----- sv/scale2x_scale3x_pixel_upscaler.sv -----
// ----------------------------------------------------------------------------
// scale2x_scale3x_pixel_upscaler
// Streaming Scale2x upscaler with two line buffers, copy / 2x modes.
// ----------------------------------------------------------------------------
// Usage:
// Source pixels enter on the in channel in raster order, one per transfer.
// Each pixel of row y > 0 releases one block for the pixel above it; the
// first row is only stored. After the last row, one flush transfer per
// column releases the last row, the final block carrying frame_end.
// Flush transfers during the pixel phase and pixel transfers during the
// flush phase are dropped without a result.
// A block passes the line buffer read registers, then the corner output
// register, before out_valid_o.
// Throughput is one item per cycle while in_stall_o is low, as each item
// takes one pass through the line buffers.
// Reset clears the counters and control, returns the registers to 2x,
// 256 by 192; line buffer contents stay undefined until written.
// When the receiver stalls, the output register and the read stage hold;
// in_stall_o rises only when both are full.
// Configuration writes take effect at once and belong between frames.
// ----------------------------------------------------------------------------
module scale2x_scale3x_pixel_upscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [s2x_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [s2x_pkg::DimW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  s2x_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output s2x_pkg::out_item_t            out_data_o
);

  // configuration
  logic [s2x_pkg::ModeW-1:0] mode_q;
  logic [s2x_pkg::DimW-1:0]  width_q;
  logic [s2x_pkg::DimW-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= s2x_pkg::Mode2x;
      width_q  <= s2x_pkg::LineWidthReset;
      height_q <= s2x_pkg::FrameHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        s2x_pkg::CfgScaleMode:   mode_q   <= cfg_data_i[s2x_pkg::ModeW-1:0];
        s2x_pkg::CfgLineWidth:   width_q  <= cfg_data_i;
        s2x_pkg::CfgFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [s2x_pkg::LenW-1:0]    line_w;
  logic [s2x_pkg::RowLenW-1:0] frame_h;

  always_comb begin
    if (width_q < s2x_pkg::DimW'(2)) begin
      line_w = s2x_pkg::LenW'(2);
    end else if (32'(width_q) > s2x_pkg::MaxLine) begin
      line_w = s2x_pkg::LenW'(s2x_pkg::MaxLine);
    end else begin
      line_w = s2x_pkg::LenW'(width_q);
    end
    if (height_q < s2x_pkg::DimW'(2)) begin
      frame_h = s2x_pkg::RowLenW'(2);
    end else if (32'(height_q) > s2x_pkg::MaxRows) begin
      frame_h = s2x_pkg::RowLenW'(s2x_pkg::MaxRows);
    end else begin
      frame_h = s2x_pkg::RowLenW'(height_q);
    end
  end

  // position counters
  logic [s2x_pkg::ColW-1:0] col_q, col_d;
  logic [s2x_pkg::RowW-1:0] row_q, row_d;
  logic                     flush_q, flush_d;

  // read stage
  logic                     s1_valid_q, s1_valid_d;
  logic [s2x_pkg::ColW-1:0] s1_x_q;
  logic [s2x_pkg::RowW-1:0] s1_y_q;
  logic [s2x_pkg::PixW-1:0] s1_h_q;
  logic [s2x_pkg::PixW-1:0] s1_left_q;
  logic                     s1_bself_q, s1_dself_q, s1_hself_q, s1_fend_q;
  logic [s2x_pkg::PixW-1:0] mid_e_q, mid_f_q, up_q;

  // write-back of the row above, in the cycle after a pixel block transfer
  logic                     wb_q, wb_up_q;
  logic [s2x_pkg::PixW-1:0] left_q;

  logic out_valid_q;
  s2x_pkg::out_item_t out_q;

  logic in_accept, is_pixel, is_flush, last_col, last_row;
  logic emit_pix, emit_flush, emit, mid_we, s1_go;
  logic [s2x_pkg::ColW-1:0] mid_ra2;

  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_pixel   = (in_data_i.kind == s2x_pkg::KindPixel);
  assign is_flush   = (in_data_i.kind == s2x_pkg::KindFlush);
  assign last_col   = (s2x_pkg::LenW'(col_q) + s2x_pkg::LenW'(1)) >= line_w;
  assign last_row   = (s2x_pkg::RowLenW'(row_q) + s2x_pkg::RowLenW'(1)) >= frame_h;
  assign emit_pix   = in_accept && !flush_q && is_pixel && (row_q != '0);
  assign emit_flush = in_accept && flush_q && is_flush;
  assign emit       = emit_pix || emit_flush;
  assign mid_we     = in_accept && !flush_q && is_pixel;
  assign mid_ra2    = last_col ? col_q : col_q + s2x_pkg::ColW'(1);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (emit_flush) begin
      if (last_col) begin
        col_d   = '0;
        row_d   = '0;
        flush_d = 1'b0;
      end else begin
        col_d = col_q + s2x_pkg::ColW'(1);
      end
    end else if (mid_we) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          flush_d = 1'b1;
        end else begin
          row_d = row_q + s2x_pkg::RowW'(1);
        end
      end else begin
        col_d = col_q + s2x_pkg::ColW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      flush_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      wb_q        <= 1'b0;
      wb_up_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      flush_q    <= flush_d;
      s1_valid_q <= s1_valid_d;
      wb_q       <= emit;
      wb_up_q    <= emit_pix;
      if (wb_q) begin
        left_q <= mid_e_q;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_x_q     <= col_q;
      s1_y_q     <= flush_q ? row_q : row_q - s2x_pkg::RowW'(1);
      s1_h_q     <= in_data_i.pixel;
      s1_left_q  <= wb_q ? mid_e_q : left_q;
      s1_bself_q <= flush_q ? (row_q == '0) : (row_q == s2x_pkg::RowW'(1));
      s1_dself_q <= (col_q == '0);
      s1_hself_q <= flush_q;
      s1_fend_q  <= flush_q && last_col;
    end
  end

  // line buffers, read-first
  logic [s2x_pkg::PixW-1:0] mid_mem [s2x_pkg::MaxLine];
  logic [s2x_pkg::PixW-1:0] up_mem  [s2x_pkg::MaxLine];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      mid_e_q <= mid_mem[col_q];
      mid_f_q <= mid_mem[mid_ra2];
    end
    if (mid_we) begin
      mid_mem[col_q] <= in_data_i.pixel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      up_q <= up_mem[col_q];
    end
    if (wb_up_q) begin
      up_mem[s1_x_q] <= mid_e_q;
    end
  end

  // corner evaluation
  s2x_pkg::nbr_t     nbr;
  s2x_pkg::corners_t corners;

  always_comb begin
    nbr.e = mid_e_q;
    nbr.b = s1_bself_q ? mid_e_q : up_q;
    nbr.d = s1_dself_q ? mid_e_q : s1_left_q;
    nbr.f = mid_f_q;
    nbr.h = s1_hself_q ? mid_e_q : s1_h_q;
  end

  s2x_corners u_corners (
    .nbr_i     (nbr),
    .copy_i    (mode_q == s2x_pkg::ModeCopy),
    .corners_o (corners)
  );

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.src_x        <= s2x_pkg::CoordW'(s1_x_q);
      out_q.src_y        <= s2x_pkg::CoordW'(s1_y_q);
      out_q.top_left     <= corners.e0;
      out_q.top_right    <= corners.e1;
      out_q.bottom_left  <= corners.e2;
      out_q.bottom_right <= corners.e3;
      out_q.center       <= mid_e_q;
      out_q.frame_end    <= s1_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_up_wr_rd_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_up_q && emit |-> s1_x_q != col_q)
    else $error("row buffer write and read hit the same column");

  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_flush && last_col |=> !flush_q && col_q == '0 && row_q == '0)
    else $error("counters not cleared at end of flush");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_x_q) && $stable(mid_e_q))
    else $error("read stage lost a block under stall");
`endif

endmodule

// ----- sv/s2x_corners.sv -----
// ----------------------------------------------------------------------------
// s2x_corners
// Scale2x corner selection from the five neighbours of a source pixel, or copy of the centre.
// ----------------------------------------------------------------------------
module s2x_corners (
  input  s2x_pkg::nbr_t     nbr_i,
  input  logic              copy_i,
  output s2x_pkg::corners_t corners_o
);

  logic db, bf, dh, hf;

  assign db = (nbr_i.d == nbr_i.b);
  assign bf = (nbr_i.b == nbr_i.f);
  assign dh = (nbr_i.d == nbr_i.h);
  assign hf = (nbr_i.h == nbr_i.f);

  always_comb begin
    corners_o.e0 = nbr_i.e;
    corners_o.e1 = nbr_i.e;
    corners_o.e2 = nbr_i.e;
    corners_o.e3 = nbr_i.e;
    if (!copy_i) begin
      if (db && !bf && !dh) corners_o.e0 = nbr_i.d;
      if (bf && !db && !hf) corners_o.e1 = nbr_i.f;
      if (dh && !db && !hf) corners_o.e2 = nbr_i.d;
      if (hf && !dh && !bf) corners_o.e3 = nbr_i.f;
    end
  end

endmodule
